[rtl/circle_box_collision_resolver_core_defines.svh]
// assertion macros for the circle box collision resolver
// used by the top level only, no other dependencies
`ifndef CIRCLE_BOX_COLLISION_RESOLVER_CORE_DEFINES_SVH
`define CIRCLE_BOX_COLLISION_RESOLVER_CORE_DEFINES_SVH

// same-cycle implication
`define CBCR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBCR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cbcr_pkg.sv]
// shared types and constants of the circle box collision resolver
// no dependencies
`default_nettype none
package cbcr_pkg;

	localparam int MAX_BOXES_DEF = 64;
	localparam int COORD_W       = 32;
	localparam int RAD_W         = 31;
	localparam int NORM_W        = 16;
	localparam int UNIT_Q14      = 16384;

	typedef enum logic [1:0] {
		CMD_LOAD_OBSTACLE = 2'd0,
		CMD_LOAD_BOUNDARY = 2'd1,
		CMD_CLEAR         = 2'd2,
		CMD_QUERY         = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SCAN_ADDR,
		ST_SCAN_READ,
		ST_CLAMP,
		ST_ABS,
		ST_MUL_X,
		ST_MUL_Z,
		ST_MUL_R,
		ST_TEST,
		ST_SQRT,
		ST_DIV_SETUP,
		ST_DIV,
		ST_DIV_END,
		ST_FACE,
		ST_FACE_PEN,
		ST_CAND,
		ST_PUSH_X_MUL,
		ST_PUSH_X_ADD,
		ST_PUSH_Z_MUL,
		ST_PUSH_Z_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                      kind;
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_z;
	} box_t;

	typedef struct packed {
		logic                      status;
		logic                      collided;
		logic signed [NORM_W-1:0]  push_x;
		logic signed [NORM_W-1:0]  push_z;
		logic [RAD_W-1:0]          depth;
		logic signed [COORD_W-1:0] moved_x;
		logic signed [COORD_W-1:0] moved_z;
	} res_t;

endpackage
`default_nettype wire

[rtl/cbcr_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module cbcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

[rtl/circle_box_collision_resolver_core.sv]
// top level of the circle box collision resolver
// uses cbcr_pkg, cbcr_ram and the assertion macro header
//
// usage
//   command channel (cmd_valid / cmd_stall) takes one word: a command code
//   and its operands. load obstacle / load boundary append a box to the
//   table, clear empties it, query tests a circle against every stored box,
//   obstacles first then boundaries, each in load order
//   result channel (res_valid / res_stall) returns exactly one word per
//   command: status, hit flag, q1.14 normal, depth and pushed-out centre
//   a load or clear passes from idle to the emit state, which loads its word into the output register once it is free
//   query: each pass steps through the stored boxes with an address and a
//   read state each and closes on a last address state; a box of the pass
//   kind goes to clamp and range check, then, when in range, to the squares
//   and radius test, then for a hit to the square root and two quotients,
//   or to the face search when the centre is inside; after the last pass
//   come the push-out and the load of the output register; these steps share
//   one 32x32 multiplier, the root and divide step units and the table read port
//   one command is in flight at a time; cmd_stall is high while it works
//   the output register lets the next command be taken while a result waits
//   reset clears the table count and all control state; the box table has
//   no clearing pass, entries above the count are never read
//   a held res_stall keeps the result word steady and stalls further output
`default_nettype none
`include "circle_box_collision_resolver_core_defines.svh"
module circle_box_collision_resolver_core #(
	parameter int MAX_BOXES = cbcr_pkg::MAX_BOXES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cmd_valid,
	output logic                                    cmd_stall,
	input  wire logic [1:0]                         command,
	input  wire logic signed [cbcr_pkg::COORD_W-1:0] box_left,
	input  wire logic signed [cbcr_pkg::COORD_W-1:0] box_right,
	input  wire logic signed [cbcr_pkg::COORD_W-1:0] box_near,
	input  wire logic signed [cbcr_pkg::COORD_W-1:0] box_far,
	input  wire logic signed [cbcr_pkg::COORD_W-1:0] centre_x,
	input  wire logic signed [cbcr_pkg::COORD_W-1:0] centre_z,
	input  wire logic [cbcr_pkg::RAD_W-1:0]          circle_radius,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output logic                                    status,
	output logic                                    collided,
	output logic signed [cbcr_pkg::NORM_W-1:0]      push_x,
	output logic signed [cbcr_pkg::NORM_W-1:0]      push_z,
	output logic [cbcr_pkg::RAD_W-1:0]              depth,
	output logic signed [cbcr_pkg::COORD_W-1:0]     moved_x,
	output logic signed [cbcr_pkg::COORD_W-1:0]     moved_z
);
	import cbcr_pkg::*;

	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int BOX_W = $bits(box_t);
	localparam logic [RAD_W-1:0] DEPTH_MAX = {RAD_W{1'b1}};

	// saturate a 34 bit sum to the signed coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = 34'sh0_7FFF_FFFF;
		lo = -hi - 34'sd1;
		if (v > hi) begin
			sat_coord = hi[COORD_W-1:0];
		end else if (v < lo) begin
			sat_coord = lo[COORD_W-1:0];
		end else begin
			sat_coord = v[COORD_W-1:0];
		end
	endfunction

	state_t state_q, state_d;

	// table
	logic [CW-1:0] count_q;
	logic          wr_en;
	logic          load_full;
	box_t          wr_box, rd_box;

	// query operands and scan position
	logic signed [COORD_W-1:0] cx_q, cz_q;
	logic [RAD_W-1:0]          r_q;
	logic [CW-1:0]             idx_q;
	logic                      pass_q;
	box_t                      box_q;

	// per-box datapath
	logic signed [32:0] dx_q, dz_q;
	logic [RAD_W-1:0]   ax_q, az_q;
	logic [63:0]        mul_q, dsq_q;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;
	logic [63:0]        sq_v_q, sq_res_q, sq_bit_q;
	logic [31:0]        dist_q;
	logic [46:0]        rem_q;
	logic [45:0]        dvs_q;
	logic [14:0]        quo_q;
	logic [3:0]         step_q;
	logic               div_z_q;
	logic signed [32:0] best_f_q;
	logic [1:0]         best_k_q, face_k_q;
	logic signed [NORM_W-1:0] cand_nx_q, cand_nz_q;
	logic [RAD_W-1:0]   cand_pen_q;

	// best hit so far
	logic                     hit_q;
	logic signed [NORM_W-1:0] bnx_q, bnz_q;
	logic [RAD_W-1:0]         bpen_q;
	logic signed [COORD_W-1:0] mx_q;

	// result staging and output register
	res_t res_q, out_q;
	logic out_valid_q;

	logic cmd_acc, out_free;

	assign cmd_acc  = cmd_valid && !cmd_stall;
	assign out_free = !out_valid_q || !res_stall;

	// load refused because every table entry is taken
	assign load_full = (command == CMD_LOAD_OBSTACLE || command == CMD_LOAD_BOUNDARY)
		&& count_q == CW'(MAX_BOXES);

	assign wr_box = '{kind: command[0], lo_x: box_left, hi_x: box_right,
		lo_z: box_near, hi_z: box_far};

	cbcr_ram #(
		.WIDTH (BOX_W),
		.DEPTH (MAX_BOXES),
		.AW    (AW)
	) u_box_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_box),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_box)
	);

	// shared multiplier
	assign mul_p = mul_a * mul_b;

	// clamp of the centre into the box, inverted boxes take the low bound test first
	logic signed [COORD_W-1:0] px, pz;
	always_comb begin
		px = (cx_q < box_q.lo_x) ? box_q.lo_x : ((cx_q > box_q.hi_x) ? box_q.hi_x : cx_q);
		pz = (cz_q < box_q.lo_z) ? box_q.lo_z : ((cz_q > box_q.hi_z) ? box_q.hi_z : cz_q);
	end

	logic [32:0] ax_w, az_w;
	assign ax_w = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign az_w = dz_q[32] ? 33'(-dz_q) : 33'(dz_q);

	// root step
	logic [63:0] sq_try;
	assign sq_try = sq_res_q + sq_bit_q;

	// divide step and quotient clamp
	logic        div_take;
	logic [14:0] quo_next, quo_clamp;
	logic signed [NORM_W-1:0] quo_signed;
	assign div_take  = rem_q >= {1'b0, dvs_q};
	assign quo_next  = {quo_q[13:0], div_take};
	assign quo_clamp = (quo_q > 15'(UNIT_Q14)) ? 15'(UNIT_Q14) : quo_q;
	always_comb begin
		if (div_z_q) begin
			quo_signed = dz_q[32] ? -$signed({1'b0, quo_clamp}) : $signed({1'b0, quo_clamp});
		end else begin
			quo_signed = dx_q[32] ? -$signed({1'b0, quo_clamp}) : $signed({1'b0, quo_clamp});
		end
	end

	// face distance picked by the face counter
	logic signed [32:0] face_f;
	always_comb begin
		case (face_k_q)
			2'd1:    face_f = {box_q.hi_x[31], box_q.hi_x} - {cx_q[31], cx_q};
			2'd2:    face_f = {cz_q[31], cz_q} - {box_q.lo_z[31], box_q.lo_z};
			2'd3:    face_f = {box_q.hi_z[31], box_q.hi_z} - {cz_q[31], cz_q};
			default: face_f = {cx_q[31], cx_q} - {box_q.lo_x[31], box_q.lo_x};
		endcase
	end

	logic signed [33:0] face_d;
	assign face_d = $signed({3'b000, r_q}) + {best_f_q[32], best_f_q};

	// push-out amount along one axis
	logic [32:0]        push_m;
	logic signed [33:0] push_sum;
	logic               push_neg;
	always_comb begin
		push_m   = 33'((mul_q[46:0] + 47'd8192) >> 14);
		push_neg = (state_q == ST_PUSH_Z_ADD) ? bnz_q[NORM_W-1] : bnx_q[NORM_W-1];
		if (state_q == ST_PUSH_Z_ADD) begin
			push_sum = {{2{cz_q[31]}}, cz_q};
		end else begin
			push_sum = {{2{cx_q[31]}}, cx_q};
		end
		push_sum = push_neg ? push_sum - $signed({1'b0, push_m})
			: push_sum + $signed({1'b0, push_m});
	end

	logic [14:0] bnx_mag, bnz_mag;
	assign bnx_mag = bnx_q[NORM_W-1] ? 15'(-bnx_q) : 15'(bnx_q);
	assign bnz_mag = bnz_q[NORM_W-1] ? 15'(-bnz_q) : 15'(bnz_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, handshake and multiplier operands
	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		wr_en     = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					if (command == CMD_QUERY) begin
						state_d = ST_SCAN_ADDR;
					end else begin
						state_d = ST_EMIT;
					end
					if ((command == CMD_LOAD_OBSTACLE || command == CMD_LOAD_BOUNDARY)
						&& count_q != CW'(MAX_BOXES)) begin
						wr_en = 1'b1;
					end
				end
			end
			ST_SCAN_ADDR: begin
				if (idx_q != count_q) begin
					state_d = ST_SCAN_READ;
				end else if (pass_q) begin
					state_d = ST_PUSH_X_MUL;
				end
			end
			ST_SCAN_READ: begin
				state_d = (rd_box.kind == pass_q) ? ST_CLAMP : ST_SCAN_ADDR;
			end
			ST_CLAMP: state_d = ST_ABS;
			ST_ABS: begin
				if (ax_w > {2'b00, r_q} || az_w > {2'b00, r_q}) begin
					state_d = ST_SCAN_ADDR;
				end else begin
					state_d = ST_MUL_X;
				end
			end
			ST_MUL_X: begin
				mul_a   = {1'b0, ax_q};
				mul_b   = {1'b0, ax_q};
				state_d = ST_MUL_Z;
			end
			ST_MUL_Z: begin
				mul_a   = {1'b0, az_q};
				mul_b   = {1'b0, az_q};
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				mul_a   = {1'b0, r_q};
				mul_b   = {1'b0, r_q};
				state_d = ST_TEST;
			end
			ST_TEST: begin
				if (dsq_q > mul_q) begin
					state_d = ST_SCAN_ADDR;
				end else if (dsq_q == '0) begin
					state_d = ST_FACE;
				end else begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sq_bit_q == '0) begin
					state_d = ST_DIV_SETUP;
				end
			end
			ST_DIV_SETUP: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == 4'd14) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: state_d = div_z_q ? ST_CAND : ST_DIV;
			ST_FACE: begin
				if (face_k_q == 2'd3) begin
					state_d = ST_FACE_PEN;
				end
			end
			ST_FACE_PEN: state_d = ST_CAND;
			ST_CAND:     state_d = ST_SCAN_ADDR;
			ST_PUSH_X_MUL: begin
				mul_a   = {17'd0, bnx_mag};
				mul_b   = {1'b0, bpen_q};
				state_d = ST_PUSH_X_ADD;
			end
			ST_PUSH_X_ADD: state_d = ST_PUSH_Z_MUL;
			ST_PUSH_Z_MUL: begin
				mul_a   = {17'd0, bnz_mag};
				mul_b   = {1'b0, bpen_q};
				state_d = ST_PUSH_Z_ADD;
			end
			ST_PUSH_Z_ADD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_acc && command == CMD_CLEAR) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_a != '0 || mul_b != '0 || state_q == ST_MUL_X || state_q == ST_MUL_Z
			|| state_q == ST_MUL_R || state_q == ST_PUSH_X_MUL || state_q == ST_PUSH_Z_MUL) begin
			mul_q <= mul_p;
		end
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cx_q   <= centre_x;
					cz_q   <= centre_z;
					r_q    <= circle_radius;
					idx_q  <= '0;
					pass_q <= 1'b0;
					hit_q  <= 1'b0;
					bnx_q  <= '0;
					bnz_q  <= '0;
					bpen_q <= '0;
					// status is the leading field of the word
					res_q  <= {load_full, {($bits(res_t) - 1){1'b0}}};
				end
			end
			ST_SCAN_ADDR: begin
				if (idx_q == count_q && !pass_q) begin
					pass_q <= 1'b1;
					idx_q  <= '0;
				end
			end
			ST_SCAN_READ: begin
				box_q <= rd_box;
				if (rd_box.kind != pass_q) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_CLAMP: begin
				dx_q <= {cx_q[31], cx_q} - {px[31], px};
				dz_q <= {cz_q[31], cz_q} - {pz[31], pz};
			end
			ST_ABS: begin
				ax_q <= ax_w[RAD_W-1:0];
				az_q <= az_w[RAD_W-1:0];
				if (ax_w > {2'b00, r_q} || az_w > {2'b00, r_q}) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_MUL_Z: dsq_q <= mul_q;
			ST_MUL_R: dsq_q <= dsq_q + mul_q;
			ST_TEST: begin
				if (dsq_q > mul_q) begin
					idx_q <= idx_q + CW'(1);
				end
				best_f_q <= {cx_q[31], cx_q} - {box_q.lo_x[31], box_q.lo_x};
				best_k_q <= 2'd0;
				face_k_q <= 2'd1;
				sq_v_q   <= dsq_q;
				sq_res_q <= '0;
				sq_bit_q <= 64'd1 << 62;
			end
			ST_SQRT: begin
				if (sq_bit_q == '0) begin
					dist_q <= sq_res_q[31:0];
				end else begin
					if (sq_v_q >= sq_try) begin
						sq_v_q   <= sq_v_q - sq_try;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
				end
			end
			ST_DIV_SETUP: begin
				rem_q      <= {2'b00, ax_q, 14'd0} + 47'(dist_q >> 1);
				dvs_q      <= {dist_q, 14'd0};
				quo_q      <= '0;
				step_q     <= '0;
				div_z_q    <= 1'b0;
				cand_pen_q <= r_q - dist_q[RAD_W-1:0];
			end
			ST_DIV: begin
				if (div_take) begin
					rem_q <= rem_q - {1'b0, dvs_q};
				end
				quo_q  <= quo_next;
				dvs_q  <= dvs_q >> 1;
				step_q <= step_q + 4'd1;
			end
			ST_DIV_END: begin
				if (div_z_q) begin
					cand_nz_q <= quo_signed;
				end else begin
					cand_nx_q <= quo_signed;
					rem_q     <= {2'b00, az_q, 14'd0} + 47'(dist_q >> 1);
					dvs_q     <= {dist_q, 14'd0};
					quo_q     <= '0;
					step_q    <= '0;
					div_z_q   <= 1'b1;
				end
			end
			ST_FACE: begin
				if (face_f < best_f_q) begin
					best_f_q <= face_f;
					best_k_q <= face_k_q;
				end
				face_k_q <= face_k_q + 2'd1;
			end
			ST_FACE_PEN: begin
				if (face_d < 0) begin
					cand_pen_q <= '0;
				end else if (face_d > $signed({3'b000, DEPTH_MAX})) begin
					cand_pen_q <= DEPTH_MAX;
				end else begin
					cand_pen_q <= face_d[RAD_W-1:0];
				end
				case (best_k_q)
					2'd0: begin
						cand_nx_q <= -NORM_W'(UNIT_Q14);
						cand_nz_q <= '0;
					end
					2'd1: begin
						cand_nx_q <= NORM_W'(UNIT_Q14);
						cand_nz_q <= '0;
					end
					2'd2: begin
						cand_nx_q <= '0;
						cand_nz_q <= -NORM_W'(UNIT_Q14);
					end
					default: begin
						cand_nx_q <= '0;
						cand_nz_q <= NORM_W'(UNIT_Q14);
					end
				endcase
			end
			ST_CAND: begin
				// strict compare keeps the first of equal depths
				if (!hit_q || cand_pen_q < bpen_q) begin
					hit_q  <= 1'b1;
					bpen_q <= cand_pen_q;
					bnx_q  <= cand_nx_q;
					bnz_q  <= cand_nz_q;
				end
				idx_q <= idx_q + CW'(1);
			end
			ST_PUSH_X_ADD: mx_q <= sat_coord(push_sum);
			ST_PUSH_Z_ADD: begin
				res_q.status   <= 1'b0;
				res_q.collided <= hit_q;
				res_q.push_x   <= bnx_q;
				res_q.push_z   <= bnz_q;
				res_q.depth    <= bpen_q;
				res_q.moved_x  <= mx_q;
				res_q.moved_z  <= sat_coord(push_sum);
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = out_valid_q;
	assign status    = out_q.status;
	assign collided  = out_q.collided;
	assign push_x    = out_q.push_x;
	assign push_z    = out_q.push_z;
	assign depth     = out_q.depth;
	assign moved_x   = out_q.moved_x;
	assign moved_z   = out_q.moved_z;

	// table never holds more boxes than it has room for
	`CBCR_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(MAX_BOXES), "count overflow")
	// an accepted word always starts work
	`CBCR_ASSERT_NXT(a_accept_busy, clk, arst_n, cmd_acc, state_q != ST_IDLE, "accept lost")
	// a refused load never reports a hit
	`CBCR_ASSERT_IMP(a_status_hit, clk, arst_n, out_valid_q && out_q.status, !out_q.collided, "status with hit")
	// x part of the normal stays within unit magnitude
	`CBCR_ASSERT_IMP(a_norm_range, clk, arst_n, out_valid_q, out_q.push_x <= 16'sd16384 && out_q.push_x >= -16'sd16384, "normal range")
endmodule
`default_nettype wire

[tb/sv/circle_box_collision_resolver_core_tb.sv]
// testbench for the circle box collision resolver top level
// depends on cbcr_pkg and circle_box_collision_resolver_core; self-checking with its own predictor
`default_nettype none
module circle_box_collision_resolver_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbcr_pkg::*;

	localparam int TABLE_DEPTH = 64;

	logic                      clk;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_stall;
	logic [1:0]                command;
	logic signed [COORD_W-1:0] box_left, box_right, box_near, box_far;
	logic signed [COORD_W-1:0] centre_x, centre_z;
	logic [RAD_W-1:0]          circle_radius;
	logic                      res_valid;
	logic                      res_stall;
	logic                      status, collided;
	logic signed [NORM_W-1:0]  push_x, push_z;
	logic [RAD_W-1:0]          depth;
	logic signed [COORD_W-1:0] moved_x, moved_z;

	circle_box_collision_resolver_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .command(command),
		.box_left(box_left), .box_right(box_right), .box_near(box_near), .box_far(box_far),
		.centre_x(centre_x), .centre_z(centre_z), .circle_radius(circle_radius),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .collided(collided), .push_x(push_x), .push_z(push_z),
		.depth(depth), .moved_x(moved_x), .moved_z(moved_z)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow box table and result words still owed by the block
	longint shadow_lo_x[TABLE_DEPTH], shadow_hi_x[TABLE_DEPTH];
	longint shadow_lo_z[TABLE_DEPTH], shadow_hi_z[TABLE_DEPTH];
	bit     shadow_kind[TABLE_DEPTH];
	int     shadow_count;
	res_t   owed_words[$];

	int errors, n_loads, n_refused, n_clears, n_queries, n_hits;
	int send_idle_pct, stall_pct;

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint absval(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// one box against the circle; normal in q1.14 and clamped depth on a hit
	function automatic bit box_hit(input int i, input longint cx, input longint cz,
			input longint r, output longint nx, output longint nz, output longint pen);
		longint lx, hx, lz, hz, px, pz, dx, dz, ax, az, dsq, root_d, qx, qz, dd;
		longint f[4];
		int best;
		lx = shadow_lo_x[i]; hx = shadow_hi_x[i];
		lz = shadow_lo_z[i]; hz = shadow_hi_z[i];
		nx = 0; nz = 0; pen = 0;
		px = cx < lx ? lx : (cx > hx ? hx : cx);
		pz = cz < lz ? lz : (cz > hz ? hz : cz);
		dx = cx - px; dz = cz - pz;
		ax = absval(dx); az = absval(dz);
		if (ax > r || az > r) return 1'b0;
		dsq = ax * ax + az * az;
		if (dsq > r * r) return 1'b0;
		if (dsq == 0) begin
			// centre inside: nearest face, min x, max x, min z, max z order
			f[0] = cx - lx; f[1] = hx - cx; f[2] = cz - lz; f[3] = hz - cz;
			best = 0;
			for (int k = 1; k < 4; k++)
				if (f[k] < f[best]) best = k;
			nx = best == 0 ? -UNIT_Q14 : (best == 1 ? UNIT_Q14 : 0);
			nz = best == 2 ? -UNIT_Q14 : (best == 3 ? UNIT_Q14 : 0);
			dd = r + f[best];
			pen = dd < 0 ? 0 : (dd > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : dd);
		end else begin
			root_d = longint'(floor_root(dsq));
			qx = (ax * UNIT_Q14 + root_d / 2) / root_d;
			qz = (az * UNIT_Q14 + root_d / 2) / root_d;
			if (qx > UNIT_Q14) qx = UNIT_Q14;
			if (qz > UNIT_Q14) qz = UNIT_Q14;
			nx = dx < 0 ? -qx : qx;
			nz = dz < 0 ? -qz : qz;
			pen = r - root_d;
		end
		return 1'b1;
	endfunction

	function automatic longint push_step(input longint n, input longint pen);
		longint m;
		m = (absval(n) * pen + 8192) >>> 14;
		return n < 0 ? -m : m;
	endfunction

	function automatic longint sat32(input longint v);
		return v > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF : (v < -64'sh8000_0000 ? -64'sh8000_0000 : v);
	endfunction

	// update the shadow table and work out the word one accepted command gives
	function automatic res_t resolve_word(input cmd_t cmd,
			input logic signed [31:0] bl, br, bn, bf, cx_in, cz_in, input logic [30:0] rad);
		res_t w;
		longint cx, cz, r, nx, nz, pen, bnx, bnz, bpen, mx, mz;
		bit hit;
		w = '0;
		case (cmd)
			CMD_LOAD_OBSTACLE, CMD_LOAD_BOUNDARY: begin
				if (shadow_count >= TABLE_DEPTH) begin
					w.status = 1'b1;
					n_refused++;
				end else begin
					shadow_lo_x[shadow_count] = longint'(bl);
					shadow_hi_x[shadow_count] = longint'(br);
					shadow_lo_z[shadow_count] = longint'(bn);
					shadow_hi_z[shadow_count] = longint'(bf);
					shadow_kind[shadow_count] = (cmd == CMD_LOAD_BOUNDARY);
					shadow_count++;
					n_loads++;
				end
			end
			CMD_CLEAR: begin
				shadow_count = 0;
				n_clears++;
			end
			default: begin
				cx = longint'(cx_in); cz = longint'(cz_in); r = longint'(rad);
				hit = 1'b0; bnx = 0; bnz = 0; bpen = 0;
				for (int pass = 0; pass < 2; pass++)
					for (int i = 0; i < shadow_count; i++)
						if (shadow_kind[i] == pass && box_hit(i, cx, cz, r, nx, nz, pen)
								&& (!hit || pen < bpen)) begin
							hit = 1'b1; bpen = pen; bnx = nx; bnz = nz;
						end
				mx = cx; mz = cz;
				if (hit) begin
					mx = sat32(cx + push_step(bnx, bpen));
					mz = sat32(cz + push_step(bnz, bpen));
					n_hits++;
				end
				n_queries++;
				w.collided = hit;
				w.push_x   = bnx[15:0];
				w.push_z   = bnz[15:0];
				w.depth    = bpen[30:0];
				w.moved_x  = mx[31:0];
				w.moved_z  = mz[31:0];
			end
		endcase
		return w;
	endfunction

	// present one word, wait for acceptance, record the owed result
	task automatic send_word(input cmd_t cmd, input logic signed [31:0] bl, br, bn, bf,
			input logic signed [31:0] cx, cz, input logic [30:0] rad);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd_valid <= 1'b1;
		command <= cmd;
		box_left <= bl; box_right <= br; box_near <= bn; box_far <= bf;
		centre_x <= cx; centre_z <= cz; circle_radius <= rad;
		do @(posedge clk); while (cmd_stall);
		owed_words.insert(owed_words.size(), resolve_word(cmd, bl, br, bn, bf, cx, cz, rad));
	endtask

	// receiver stall pattern
	always @(negedge clk)
		res_stall <= ($urandom_range(99) < stall_pct);

	// compare each accepted result word with the oldest owed one
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && res_valid && !res_stall) begin
			got = '{status, collided, push_x, push_z, depth, moved_x, moved_z};
			if (owed_words.size() == 0) begin
				$display("%0t: result word with none owed, actual %h", $realtime, got);
				errors++;
			end else begin
				want = owed_words.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
					errors++;
				end
				if (got.collided !== want.collided) begin
					$display("%0t: collided expected %0d actual %0d", $realtime,
						want.collided, got.collided);
					errors++;
				end
				if (got.push_x !== want.push_x) begin
					$display("%0t: push_x expected %0d actual %0d", $realtime, want.push_x, got.push_x);
					errors++;
				end
				if (got.push_z !== want.push_z) begin
					$display("%0t: push_z expected %0d actual %0d", $realtime, want.push_z, got.push_z);
					errors++;
				end
				if (got.depth !== want.depth) begin
					$display("%0t: depth expected %0d actual %0d", $realtime, want.depth, got.depth);
					errors++;
				end
				if (got.moved_x !== want.moved_x) begin
					$display("%0t: moved_x expected %0d actual %0d", $realtime,
						want.moved_x, got.moved_x);
					errors++;
				end
				if (got.moved_z !== want.moved_z) begin
					$display("%0t: moved_z expected %0d actual %0d", $realtime,
						want.moved_z, got.moved_z);
					errors++;
				end
			end
		end
	end

	localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CMIN = 32'sh8000_0000;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;

	task automatic query(input logic signed [31:0] cx, cz, input logic [30:0] rad);
		send_word(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, cx, cz, rad);
	endtask

	task automatic load(input cmd_t cmd, input logic signed [31:0] bl, br, bn, bf);
		send_word(cmd, bl, br, bn, bf, $urandom, $urandom, 31'($urandom));
	endtask

	// extremes, inside push-out, touching, inverted box, saturation, full table
	task automatic test_directed();
		query(0, 0, 31'h7FFF_FFFF);                    // empty table, no hit
		load(CMD_LOAD_OBSTACLE, -ONE, ONE, -ONE, ONE);
		query(0, 0, ONE);                              // centre inside, min x face
		query(ONE / 2, ONE / 4, ONE);                  // nearest face max x
		query(2 * ONE, 0, ONE);                        // touching, zero depth
		query(2 * ONE + 1, 0, ONE);                    // just out
		query(2 * ONE, 2 * ONE, 3 * ONE);              // corner, diagonal normal
		load(CMD_LOAD_BOUNDARY, 5 * ONE, 3 * ONE, 5 * ONE, 3 * ONE);  // inverted
		query(4 * ONE, 4 * ONE, 2 * ONE);
		load(CMD_LOAD_OBSTACLE, CMIN, CMAX, CMIN, CMAX);
		query(CMAX, CMIN, 31'h7FFF_FFFF);              // depth and push saturate
		query(CMIN, CMAX, 0);
		load(CMD_LOAD_BOUNDARY, CMAX - ONE, CMAX, CMAX - ONE, CMAX);
		query(CMAX, CMAX, 31'h7FFF_FFFF);
		send_word(CMD_CLEAR, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 31'h7FFF_FFFF);
		query(0, 0, ONE);                              // cleared, no hit
		// fill to the limit, then refused loads of both kinds
		for (int i = 0; i < TABLE_DEPTH; i++)
			load(i[0] ? CMD_LOAD_BOUNDARY : CMD_LOAD_OBSTACLE,
				i * ONE, i * ONE + ONE / 2, -ONE, ONE);
		load(CMD_LOAD_OBSTACLE, 0, ONE, 0, ONE);
		load(CMD_LOAD_BOUNDARY, 0, ONE, 0, ONE);
		query(10 * ONE + ONE / 4, 0, 2 * ONE);         // ties across many boxes
		send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
	endtask

	function automatic logic signed [31:0] pick_coord();
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(0, 32 * 65536)) - 16 * 65536;
	endfunction

	task automatic test_random(input int n_items);
		logic signed [31:0] a, b, c, d;
		logic [30:0] rad;
		int k;
		for (int i = 0; i < n_items; i++) begin
			k = $urandom_range(99);
			if (k < 3 || (shadow_count > 8 && k < 12)) begin
				send_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, 31'($urandom));
			end else if (k < 38) begin
				a = pick_coord(); c = pick_coord();
				if ($urandom_range(9) == 0) begin
					b = pick_coord(); d = pick_coord();  // may be inverted
				end else begin
					b = a + $urandom_range(0, 8 * 65536);
					d = c + $urandom_range(0, 8 * 65536);
				end
				load($urandom_range(1) ? CMD_LOAD_BOUNDARY : CMD_LOAD_OBSTACLE, a, b, c, d);
			end else begin
				rad = ($urandom_range(19) == 0) ? 31'($urandom) : 31'($urandom_range(0, 6 * 65536));
				query(pick_coord(), pick_coord(), rad);
			end
		end
	endtask

	initial begin
		int n;
		errors = 0; n_loads = 0; n_refused = 0; n_clears = 0; n_queries = 0; n_hits = 0;
		shadow_count = 0;
		send_idle_pct = 0; stall_pct = 0;
		arst_n = 1'b0; cmd_valid = 1'b0; res_stall = 1'b0; command = CMD_CLEAR;
		box_left = '0; box_right = '0; box_near = '0; box_far = '0;
		centre_x = '0; centre_z = '0; circle_radius = '0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		test_directed();
		send_idle_pct = 0;  stall_pct = 0;  test_random(400);
		send_idle_pct = 68; stall_pct = 0;  test_random(380);
		send_idle_pct = 0;  stall_pct = 68; test_random(380);
		send_idle_pct = 10; stall_pct = 10; test_random(390);
		@(negedge clk) cmd_valid <= 1'b0;
		n = 0;
		while (owed_words.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (100) @(posedge clk);
		if (owed_words.size() != 0) begin
			$display("%0t: %0d result words never arrived", $realtime, owed_words.size());
			errors++;
		end
		$display("covered %0d loads (%0d refused on a full table), %0d clears, %0d queries",
			n_loads, n_refused, n_clears, n_queries);
		$display("%0d queries hit a box; four handshake pressure phases", n_hits);
		if (errors == 0)
			$display("circle_box_collision_resolver_core_tb: clean");
		else
			$display("circle_box_collision_resolver_core_tb: errors");
		$finish;
	end

	// hard stop
	initial begin
		#200_000_000;
		$display("circle_box_collision_resolver_core_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire

[circle_box_collision_resolver_core.f]
+incdir+rtl
rtl/cbcr_pkg.sv
rtl/cbcr_ram.sv
rtl/circle_box_collision_resolver_core.sv
tb/sv/circle_box_collision_resolver_core_tb.sv
